@@ hw/rtl/sbda_pkg.sv @@
// Shared constants, types and helper functions of the signed binary to decimal ASCII block.
// Used by every module of the block; depends on nothing.

package sbda_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int BITS_PER_CYCLE  = 4;
    localparam int CHAR_WIDTH      = 8;
    localparam int COUNT_WIDTH     = 5;
    localparam int MAX_CHARS       = 20;

    localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_WIDTH-1:0] ASCII_NINE  = 8'd57;
    localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 8'd45;

    typedef logic [3:0] t_bcd;

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_RUN,
        CV_DONE
    } t_conv_state;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_SIGN,
        EM_DIGIT
    } t_emit_state;

    typedef struct packed {
        logic valid;
        logic neg;
    } t_job_ctl;

    function automatic t_bcd bcd_adjust(input t_bcd d);
        return (d >= 4'd5) ? t_bcd'(d + 4'd3) : d;
    endfunction

endpackage

@@ hw/rtl/sbda_front.sv @@
// Front part: accepts input words, forms sign and magnitude, and holds them in a two-entry queue.
// Depends on sbda_pkg.

module sbda_front
    import sbda_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    output logic                   o_full,
    input  logic [63:0]            i_value,
    output t_job_ctl               o_job,
    input  logic                   i_job_take,
    output logic [VALUE_WIDTH-1:0] o_job_mag
);

    logic [VALUE_WIDTH-1:0] r_mag [2];
    logic                   r_neg [2];
    logic                   r_wptr;
    logic                   r_rptr;
    logic [1:0]             r_cnt;

    logic [VALUE_WIDTH-1:0] value_low;
    logic                   value_neg;
    logic [VALUE_WIDTH-1:0] value_mag;
    logic                   push_ok;
    logic                   pop_ok;

    assign value_low = i_value[VALUE_WIDTH-1:0];
    assign value_neg = value_low[VALUE_WIDTH-1];
    assign value_mag = value_neg ? VALUE_WIDTH'(~value_low + 1'b1) : value_low;

    assign o_full     = r_cnt[1];
    assign o_job.valid = (r_cnt != 2'd0);
    assign o_job.neg   = r_neg[r_rptr];
    assign o_job_mag   = r_mag[r_rptr];

    assign push_ok = i_push && !o_full;
    assign pop_ok  = o_job.valid && i_job_take;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mag[r_wptr] <= value_mag;
            r_neg[r_wptr] <= value_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wptr <= !r_wptr;
            end
            if (pop_ok) begin
                r_rptr <= !r_rptr;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

@@ hw/rtl/sbda_conv.sv @@
// Back part, first stage: shift-and-add-3 conversion of a magnitude into decimal digits.
// Handles several bits per cycle. Depends on sbda_pkg.

module sbda_conv
    import sbda_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int DIGITS      = 19
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_job_ctl               i_job,
    input  logic [VALUE_WIDTH-1:0] i_job_mag,
    output logic                   o_job_take,
    output logic                   o_res_valid,
    output logic                   o_res_neg,
    output logic [DIGITS*4-1:0]    o_res_digits,
    input  logic                   i_res_take
);

    localparam int STEPS      = (VALUE_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE;
    localparam int PAD_WIDTH  = STEPS * BITS_PER_CYCLE;
    localparam int STEP_WIDTH = $clog2(STEPS + 1);

    t_conv_state           r_state;
    t_conv_state           n_state;
    logic [PAD_WIDTH-1:0]  r_bin;
    t_bcd                  r_bcd [DIGITS];
    logic                  r_neg;
    logic [STEP_WIDTH-1:0] r_steps;

    logic [PAD_WIDTH-1:0]  c_bin;
    t_bcd                  c_bcd [DIGITS];

    always_comb begin
        c_bin = r_bin;
        c_bcd = r_bcd;
        for (int b = 0; b < BITS_PER_CYCLE; b++) begin
            for (int d = 0; d < DIGITS; d++) begin
                c_bcd[d] = bcd_adjust(c_bcd[d]);
            end
            for (int d = DIGITS - 1; d > 0; d--) begin
                c_bcd[d] = {c_bcd[d][2:0], c_bcd[d-1][3]};
            end
            c_bcd[0] = {c_bcd[0][2:0], c_bin[PAD_WIDTH-1]};
            c_bin    = {c_bin[PAD_WIDTH-2:0], 1'b0};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CV_IDLE: begin
                if (i_job.valid) begin
                    n_state = CV_RUN;
                end
            end
            CV_RUN: begin
                if (r_steps == STEP_WIDTH'(1)) begin
                    n_state = CV_DONE;
                end
            end
            CV_DONE: begin
                if (i_res_take) begin
                    n_state = CV_IDLE;
                end
            end
            default: n_state = CV_IDLE;
        endcase
    end

    always_comb begin
        o_job_take  = (r_state == CV_IDLE);
        o_res_valid = (r_state == CV_DONE);
        o_res_neg   = r_neg;
        for (int d = 0; d < DIGITS; d++) begin
            o_res_digits[d*4 +: 4] = r_bcd[d];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == CV_IDLE && i_job.valid) begin
            r_bin   <= PAD_WIDTH'(i_job_mag);
            r_neg   <= i_job.neg;
            r_steps <= STEP_WIDTH'(STEPS);
            for (int d = 0; d < DIGITS; d++) begin
                r_bcd[d] <= 4'd0;
            end
        end else if (r_state == CV_RUN) begin
            r_bin   <= c_bin;
            r_bcd   <= c_bcd;
            r_steps <= r_steps - STEP_WIDTH'(1);
        end
    end

endmodule

@@ hw/rtl/sbda_emit.sv @@
// Back part, second stage: sends the sign and the digits as ASCII words through an output register.
// Depends on sbda_pkg.

module sbda_emit
    import sbda_pkg::*;
#(
    parameter int DIGITS = 19
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_res_valid,
    input  logic                   i_res_neg,
    input  logic [DIGITS*4-1:0]    i_res_digits,
    output logic                   o_res_take,
    output logic                   o_empty,
    input  logic                   i_pop,
    output logic [CHAR_WIDTH-1:0]  o_character,
    output logic                   o_last,
    output logic [COUNT_WIDTH-1:0] o_char_count
);

    localparam int IDX_WIDTH = $clog2(DIGITS);

    t_emit_state            r_state;
    t_emit_state            n_state;
    t_bcd                   r_digits [DIGITS];
    logic [IDX_WIDTH-1:0]   r_pos;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   r_out_valid;
    logic [CHAR_WIDTH-1:0]  r_out_char;
    logic                   r_out_last;
    logic [COUNT_WIDTH-1:0] r_out_count;

    logic [IDX_WIDTH-1:0]   top_idx;
    logic                   advance;
    logic                   fire;
    logic                   load;
    logic [CHAR_WIDTH-1:0]  n_char;
    logic                   n_last;
    logic [COUNT_WIDTH-1:0] n_count;

    always_comb begin
        top_idx = '0;
        for (int d = 0; d < DIGITS; d++) begin
            if (i_res_digits[d*4 +: 4] != 4'd0) begin
                top_idx = IDX_WIDTH'(d);
            end
        end
    end

    assign advance = !r_out_valid || i_pop;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            EM_IDLE: begin
                if (i_res_valid) begin
                    n_state = i_res_neg ? EM_SIGN : EM_DIGIT;
                end
            end
            EM_SIGN: begin
                if (advance) begin
                    n_state = EM_DIGIT;
                end
            end
            EM_DIGIT: begin
                if (advance && r_pos == '0) begin
                    n_state = EM_IDLE;
                end
            end
            default: n_state = EM_IDLE;
        endcase
    end

    always_comb begin
        o_res_take = (r_state == EM_IDLE);
        load       = o_res_take && i_res_valid;
        fire       = advance && (r_state != EM_IDLE);
        n_char     = ASCII_MINUS;
        n_last     = 1'b0;
        n_count    = '0;
        if (r_state == EM_DIGIT) begin
            n_char = ASCII_ZERO + {4'b0000, r_digits[r_pos]};
            n_last = (r_pos == '0);
            if (n_last) begin
                n_count = r_count + COUNT_WIDTH'(1);
            end
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_character  = r_out_char;
    assign o_last       = r_out_last;
    assign o_char_count = r_out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= EM_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (advance) begin
                r_out_valid <= fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int d = 0; d < DIGITS; d++) begin
                r_digits[d] <= i_res_digits[d*4 +: 4];
            end
            r_pos   <= top_idx;
            r_count <= '0;
        end else if (fire) begin
            r_count <= r_count + COUNT_WIDTH'(1);
            if (r_state == EM_DIGIT && r_pos != '0) begin
                r_pos <= r_pos - IDX_WIDTH'(1);
            end
        end
        if (fire) begin
            r_out_char  <= n_char;
            r_out_last  <= n_last;
            r_out_count <= n_count;
        end
    end

endmodule

@@ hw/rtl/signed_binary_to_decimal_ascii.sv @@
// Signed binary to decimal ASCII converter, top level.
// Instantiates sbda_front, sbda_conv and sbda_emit; depends on sbda_pkg.
//
// Usage:
// The input side is a queue: a word on i_value is taken at a clock edge with push high and
// full low. Only the low VALUE_WIDTH bits are used, as a two's complement number.
// The output side is a queue too: while empty is low, o_character holds the oldest ASCII
// character, and it is taken at an edge with pop high. A number leaves most significant
// character first, with a leading minus sign when negative. Its final character has o_last
// set and o_char_count equal to the number of characters; other characters carry count zero.
// A number passes the input queue, the shift-and-add-3 converter, which handles four bits per
// cycle, and the emitter with its output register. The converter can work on the next number
// while the emitter still sends the characters of the one before, so the two parts overlap.
// A two-entry input queue lets new words in while the back part is busy. When the receiver
// stalls, the output register holds its character and the emitter, converter and input queue
// fill in turn until full rises. Reset clears all queues; empty is high and full is low.

module signed_binary_to_decimal_ascii
    import sbda_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [63:0]            i_value,
    output logic                   empty,
    input  logic                   pop,
    output logic [CHAR_WIDTH-1:0]  o_character,
    output logic                   o_last,
    output logic [COUNT_WIDTH-1:0] o_char_count
);

    localparam int DIGITS = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;

    t_job_ctl               job;
    logic [VALUE_WIDTH-1:0] job_mag;
    logic                   job_take;
    logic                   res_valid;
    logic                   res_neg;
    logic [DIGITS*4-1:0]    res_digits;
    logic                   res_take;

    sbda_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_value    (i_value),
        .o_job      (job),
        .i_job_take (job_take),
        .o_job_mag  (job_mag)
    );

    sbda_conv #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIGITS      (DIGITS)
    ) u_conv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (job),
        .i_job_mag    (job_mag),
        .o_job_take   (job_take),
        .o_res_valid  (res_valid),
        .o_res_neg    (res_neg),
        .o_res_digits (res_digits),
        .i_res_take   (res_take)
    );

    sbda_emit #(
        .DIGITS (DIGITS)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res_valid  (res_valid),
        .i_res_neg    (res_neg),
        .i_res_digits (res_digits),
        .o_res_take   (res_take),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_character  (o_character),
        .o_last       (o_last),
        .o_char_count (o_char_count)
    );

endmodule

@@ hw/rtl/sbda_checker.sv @@
// Port-level checker for the signed binary to decimal ASCII block, with its bind statement.
// Depends on sbda_pkg and on the port list of signed_binary_to_decimal_ascii.

module sbda_checker
    import sbda_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   push,
    input logic                   full,
    input logic                   empty,
    input logic                   pop,
    input logic [CHAR_WIDTH-1:0]  o_character,
    input logic                   o_last,
    input logic [COUNT_WIDTH-1:0] o_char_count
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    a_count_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_last |-> o_char_count == '0)
        else $error("nonzero count on a word that is not last");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_last |-> o_char_count != '0 && o_char_count <= COUNT_WIDTH'(MAX_CHARS))
        else $error("count on last word out of range");

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_character == ASCII_MINUS
                   || (o_character >= ASCII_ZERO && o_character <= ASCII_NINE))
        else $error("word is neither a minus sign nor a digit");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_character) && $stable(o_last)
                           && $stable(o_char_count))
        else $error("waiting word changed while stalled");

endmodule

bind signed_binary_to_decimal_ascii sbda_checker u_sbda_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_character  (o_character),
    .o_last       (o_last),
    .o_char_count (o_char_count)
);
